FILE: rtl/core/bde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bde_pkg: shared types and constants of the button debouncer
// Event word layout, button count limits, lockout reset and queue sizing.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int BTN_SLOTS       = 16;
    localparam int NUM_BUTTONS_DEF = 16;
    localparam int BTN_IDX_W       = 4;
    localparam int TIME_W          = 32;
    localparam int LOCKOUT_W       = 8;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 8'd20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [BTN_IDX_W-1:0] button_index;
        logic                 is_press;
        logic                 last_event;
    } event_t;

endpackage
`default_nettype wire

FILE: rtl/core/button_debounce_event_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_event_gen: lockout-timer button debouncer
// Turns active-low button scans into press/release event words.
// ----------------------------------------------------------------------------
// A scan (raw_buttons, now_ms) is taken when the block is idle and is walked
// one button per cycle (capture, one step per button, final flush), stalling
// only while the four-word event queue is full because m_ready is held low.
// A button changes state when its inverted level differs from its pressed
// flag and the modular time since its last change is strictly above
// lockout_ms. Events leave in ascending button order; the final one of a
// scan has m_last_event set. A scan with no change produces no word.
// lockout_ms resets to 20 and the user must write it through the cfg channel
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module button_debounce_event_gen #(
    parameter int NUM_BUTTONS = bde_pkg::NUM_BUTTONS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [bde_pkg::LOCKOUT_W-1:0]     cfg_lockout_ms,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [bde_pkg::BTN_SLOTS-1:0]     s_raw_buttons,
    input  wire  [bde_pkg::TIME_W-1:0]        s_now_ms,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [bde_pkg::BTN_IDX_W-1:0]     m_button_index,
    output logic                              m_is_press,
    output logic                              m_last_event
);
    import bde_pkg::*;

    logic   push_valid;
    logic   push_ready;
    event_t push_word;
    logic   pop_valid;
    logic   pop_ready;
    event_t pop_word;

    assign cfg_ready = 1'b1;

    bde_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr           (cfg_valid),
        .cfg_lockout_ms   (cfg_lockout_ms),
        .scan_valid       (s_valid),
        .scan_ready       (s_ready),
        .scan_raw_buttons (s_raw_buttons),
        .scan_now_ms      (s_now_ms),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_word        (push_word)
    );

    bde_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    bde_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .q_word         (pop_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_button_index (m_button_index),
        .m_is_press     (m_is_press),
        .m_last_event   (m_last_event)
    );

endmodule
`default_nettype wire

FILE: rtl/core/bde_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bde_front: scan classifier
// Latches one scan, walks the buttons one per cycle unless the queue is full,
// applies the lockout, updates per-button state and pushes press/release
// words to the queue. One word is held back so a scan's final word is marked.
// ----------------------------------------------------------------------------
module bde_front #(
    parameter int NUM_BUTTONS = bde_pkg::NUM_BUTTONS_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_wr,
    input  wire  [bde_pkg::LOCKOUT_W-1:0]        cfg_lockout_ms,
    input  wire                                  scan_valid,
    output logic                                 scan_ready,
    input  wire  [bde_pkg::BTN_SLOTS-1:0]        scan_raw_buttons,
    input  wire  [bde_pkg::TIME_W-1:0]           scan_now_ms,
    output logic                                 push_valid,
    input  wire                                  push_ready,
    output bde_pkg::event_t                      push_word
);
    import bde_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam logic [BTN_IDX_W-1:0] LAST_BTN = BTN_IDX_W'(NUM_BUTTONS - 1);

    logic [1:0]             state_reg;
    logic [BTN_IDX_W-1:0]   cnt_reg;
    logic [BTN_SLOTS-1:0]   levels_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [LOCKOUT_W-1:0]   lockout_reg;
    logic [BTN_SLOTS-1:0]   pressed_reg;
    logic [TIME_W-1:0]      time_reg [BTN_SLOTS];
    logic                   pend_valid_reg;
    logic [BTN_IDX_W-1:0]   pend_idx_reg;
    logic                   pend_press_reg;

    logic                   held;
    logic [TIME_W-1:0]      elapsed;
    logic                   change;
    logic                   advance;
    logic                   flush_done;

    always_comb begin
        held       = levels_reg[cnt_reg];
        elapsed    = now_reg - time_reg[cnt_reg];
        change     = (held != pressed_reg[cnt_reg]) &&
                     (elapsed > {{(TIME_W-LOCKOUT_W){1'b0}}, lockout_reg});
        scan_ready = (state_reg == ST_IDLE);
        push_valid = ((state_reg == ST_SCAN) && change && pend_valid_reg) ||
                     ((state_reg == ST_FLUSH) && pend_valid_reg);
        push_word.button_index = pend_idx_reg;
        push_word.is_press     = pend_press_reg;
        push_word.last_event   = (state_reg == ST_FLUSH);
        advance    = (state_reg == ST_SCAN) &&
                     (!(change && pend_valid_reg) || push_ready);
        flush_done = (state_reg == ST_FLUSH) && (!pend_valid_reg || push_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            lockout_reg    <= LOCKOUT_RESET;
            pressed_reg    <= '0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < BTN_SLOTS; i++) begin
                time_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                lockout_reg <= cfg_lockout_ms;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (scan_valid) begin
                        levels_reg <= ~scan_raw_buttons;
                        now_reg    <= scan_now_ms;
                        cnt_reg    <= '0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (advance) begin
                        if (change) begin
                            pressed_reg[cnt_reg] <= held;
                            time_reg[cnt_reg]    <= now_reg;
                            pend_valid_reg       <= 1'b1;
                            pend_idx_reg         <= cnt_reg;
                            pend_press_reg       <= held;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == LAST_BTN) begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (flush_done) begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bde_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bde_queue: event word queue
// Small circular buffer between the scan classifier and the output stage.
// ----------------------------------------------------------------------------
module bde_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push_valid,
    output logic                  push_ready,
    input  wire bde_pkg::event_t  push_word,
    output logic                  pop_valid,
    input  wire                   pop_ready,
    output bde_pkg::event_t       pop_word
);
    import bde_pkg::*;

    event_t                 buf_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    always_comb begin
        push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
        pop_valid  = (count_reg != '0);
        pop_word   = buf_reg[rd_ptr_reg];
        do_push    = push_valid && push_ready;
        do_pop     = pop_valid && pop_ready;
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bde_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bde_back: event output stage
// Takes words from the queue into an output register and holds each one
// until the downstream side accepts it.
// ----------------------------------------------------------------------------
module bde_back (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               q_valid,
    output logic                              q_ready,
    input  wire bde_pkg::event_t              q_word,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [bde_pkg::BTN_IDX_W-1:0]     m_button_index,
    output logic                              m_is_press,
    output logic                              m_last_event
);
    import bde_pkg::*;

    logic   valid_reg;
    event_t word_reg;

    always_comb begin
        q_ready        = !valid_reg || m_ready;
        m_valid        = valid_reg;
        m_button_index = word_reg.button_index;
        m_is_press     = word_reg.is_press;
        m_last_event   = word_reg.last_event;
    end

    always_ff @(posedge aclk) begin
        if (q_ready) begin
            word_reg <= q_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_ready) begin
            valid_reg <= q_valid;
        end
    end

endmodule
`default_nettype wire
